[rtl/core/chip8_instruction_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the instruction core.
// Each macro expands to one labeled concurrent assertion on the rising clock,
// disabled while the active-low synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define C8_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define C8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/c8core_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_pkg
// Types, item kinds, the hex font and the controller/datapath command types.
// ----------------------------------------------------------------------------
package c8core_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = 12;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = 4;
    localparam int NUM_VREGS   = 16;
    localparam int VREG_AW     = 4;
    localparam int FRAME_ROWS  = 32;
    localparam int ROW_AW      = 5;
    localparam int FRAME_COLS  = 64;
    localparam int COL_AW      = 6;
    localparam int FONT_BYTES  = 80;
    localparam int FONT_AW     = 7;

    // Item kinds carried in the opcode field.
    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_EXEC  = 3'd1;
    localparam logic [2:0] KIND_TICK  = 3'd2;
    localparam logic [2:0] KIND_ROW   = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Hex digit glyphs, five bytes per digit, loaded at the bottom of memory.
    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
    } t_item;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] instruction_word;
        logic        illegal_instruction;
        logic        waiting_key;
        logic        sound_on;
        logic [7:0]  read_byte;
        logic [63:0] pixel_row;
    } t_result;

    // Datapath operation for the current cycle.
    typedef enum logic [4:0] {
        STEP_IDLE,
        STEP_CLEAR,
        STEP_LATCH,
        STEP_MEM_WRITE,
        STEP_TICK,
        STEP_ROW,
        STEP_RD_ADDR,
        STEP_RD_DATA,
        STEP_FETCH_HI,
        STEP_FETCH_LO,
        STEP_LOAD_VX,
        STEP_LOAD_VY,
        STEP_LOAD_V0,
        STEP_EXEC,
        STEP_FLAG,
        STEP_DRAW_RD,
        STEP_DRAW_WR,
        STEP_BCD,
        STEP_STORE_RD,
        STEP_STORE_WR,
        STEP_LOAD_RD,
        STEP_LOAD_WR,
        STEP_RESULT
    } t_step;

    // Follow-up sequence that a decoded instruction asks for.
    typedef enum logic [2:0] {
        SEQ_DONE,
        SEQ_FLAG,
        SEQ_DRAW,
        SEQ_BCD,
        SEQ_STORE,
        SEQ_LOAD
    } t_seq;

    typedef struct packed {
        t_step             step;
        logic [MEM_AW-1:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        t_seq       seq;
        logic [3:0] n;
        logic [3:0] x;
        logic       out_free;
    } t_dp_stat;

endpackage

[rtl/core/c8core_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface c8core_item_if;
    import c8core_pkg::*;
    logic  valid;
    logic  ready;
    t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface c8core_result_if;
    import c8core_pkg::*;
    logic    valid;
    logic    ready;
    t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/chip8_instruction_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 interpreter core: memory writes and reads, instruction execution,
// timer ticks and display row reads, one result beat per item.
// ----------------------------------------------------------------------------
//  Channel    Dir  Handshake     Beat
//  i_item     in   valid/ready   t_item: kind, address, data, keys, random
//  o_result   out  valid/ready   t_result: counter, word, flags, byte, row
//
//  Steps: write, tick and row read do one step, memory read an address and
//  a data step. Execute fetches two bytes, reads three registers on the
//  single read ports and executes; then a VF write, a read and write per
//  sprite row or store/load register, or a write per BCD digit may follow.
//  Reset: a pass over every memory address loads the font and clears memory
//  and V0..VF; no item is accepted during it.
//  Stalls: the result register holds its beat; the next item is accepted
//  meanwhile and its result waits until the register is free.
module chip8_instruction_core #(
    parameter int PROGRAM_START = 512
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    c8core_item_if.sink     i_item,
    c8core_result_if.source o_result
);
    import c8core_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;
    t_result  result;

    // Sequencer.
    c8core_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_opcode (i_item.payload.opcode),
        .o_in_ready  (in_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath.
    c8core_dp #(.PROGRAM_START(PROGRAM_START)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item.payload),
        .o_stat      (stat),
        .o_result    (result),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready)
    );

    assign i_item.ready     = in_ready;
    assign o_result.valid   = out_valid;
    assign o_result.payload = result;

endmodule

[rtl/core/c8core_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8core_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/c8core_ctrl.sv]
`timescale 1ns / 1ps
`include "chip8_instruction_core_defines.svh"
// ----------------------------------------------------------------------------
// c8core_ctrl
// Sequencer: runs the clearing pass, accepts items and steps the datapath
// through fetch, execute and the multi-cycle instruction loops.
// ----------------------------------------------------------------------------
module c8core_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [2:0]           i_in_opcode,
    output logic                 o_in_ready,
    input  c8core_pkg::t_dp_stat i_stat,
    output c8core_pkg::t_dp_cmd  o_cmd
);
    import c8core_pkg::*;

    localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_BYTES - 1);
    localparam logic [MEM_AW-1:0] BCD_LAST = MEM_AW'(2);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_TICK, S_ROW, S_RD0, S_RD1,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_EXEC, S_FLAG,
        S_DRAW_RD, S_DRAW_WR, S_BCD, S_STORE_RD, S_STORE_WR,
        S_LOAD_RD, S_LOAD_WR, S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [MEM_AW-1:0] r_cnt, n_cnt;
    logic [3:0]        cnt_lo;

    assign cnt_lo = r_cnt[3:0];

    // Next state, loop count and datapath command.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd.step = STEP_IDLE;
        o_cmd.cnt  = r_cnt;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.step = STEP_CLEAR;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == MEM_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.step = STEP_LATCH;
                    unique case (i_in_opcode) inside
                        KIND_WRITE: n_state = S_WRITE;
                        KIND_EXEC:  n_state = S_F0;
                        KIND_TICK:  n_state = S_TICK;
                        KIND_ROW:   n_state = S_ROW;
                        KIND_READ:  n_state = S_RD0;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.step = STEP_MEM_WRITE;
                n_state    = S_DONE;
            end
            S_TICK: begin
                o_cmd.step = STEP_TICK;
                n_state    = S_DONE;
            end
            S_ROW: begin
                o_cmd.step = STEP_ROW;
                n_state    = S_DONE;
            end
            S_RD0: begin
                o_cmd.step = STEP_RD_ADDR;
                n_state    = S_RD1;
            end
            S_RD1: begin
                o_cmd.step = STEP_RD_DATA;
                n_state    = S_DONE;
            end
            S_F0: begin
                o_cmd.step = STEP_FETCH_HI;
                n_state    = S_F1;
            end
            S_F1: begin
                o_cmd.step = STEP_FETCH_LO;
                n_state    = S_F2;
            end
            S_F2: begin
                o_cmd.step = STEP_LOAD_VX;
                n_state    = S_F3;
            end
            S_F3: begin
                o_cmd.step = STEP_LOAD_VY;
                n_state    = S_F4;
            end
            S_F4: begin
                o_cmd.step = STEP_LOAD_V0;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.step = STEP_EXEC;
                n_cnt      = '0;
                unique case (i_stat.seq)
                    SEQ_FLAG:  n_state = S_FLAG;
                    SEQ_DRAW:  n_state = S_DRAW_RD;
                    SEQ_BCD:   n_state = S_BCD;
                    SEQ_STORE: n_state = S_STORE_RD;
                    SEQ_LOAD:  n_state = S_LOAD_RD;
                    default:   n_state = S_DONE;
                endcase
            end
            S_FLAG: begin
                o_cmd.step = STEP_FLAG;
                n_state    = S_DONE;
            end
            // Sprite rows: read a byte, then merge it into the frame.
            S_DRAW_RD: begin
                o_cmd.step = STEP_DRAW_RD;
                n_state    = S_DRAW_WR;
            end
            S_DRAW_WR: begin
                o_cmd.step = STEP_DRAW_WR;
                if (cnt_lo == 4'(i_stat.n - 4'd1)) begin
                    n_state = S_FLAG;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_DRAW_RD;
                end
            end
            S_BCD: begin
                o_cmd.step = STEP_BCD;
                if (r_cnt == BCD_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_STORE_RD: begin
                o_cmd.step = STEP_STORE_RD;
                n_state    = S_STORE_WR;
            end
            S_STORE_WR: begin
                o_cmd.step = STEP_STORE_WR;
                if (cnt_lo == i_stat.x) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_STORE_RD;
                end
            end
            S_LOAD_RD: begin
                o_cmd.step = STEP_LOAD_RD;
                n_state    = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                o_cmd.step = STEP_LOAD_WR;
                if (cnt_lo == i_stat.x) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_LOAD_RD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.step = STEP_RESULT;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and loop counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Loop counts of the instruction sequences never leave the register range.
    `C8_ASSERT_IMPL(a_loop_count_small, i_clk, i_rst_n, r_state == S_DRAW_RD || r_state == S_DRAW_WR || r_state == S_STORE_RD || r_state == S_STORE_WR || r_state == S_LOAD_RD || r_state == S_LOAD_WR || r_state == S_BCD, r_cnt[MEM_AW-1:4] == '0, "loop counter out of range")

endmodule

[rtl/core/c8core_dp.sv]
`timescale 1ns / 1ps
`include "chip8_instruction_core_defines.svh"
// ----------------------------------------------------------------------------
// c8core_dp
// Datapath: memory, register file, stack, timers, frame buffer, instruction
// decode and the result register.
// ----------------------------------------------------------------------------
module c8core_dp #(
    parameter int PROGRAM_START = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  c8core_pkg::t_dp_cmd  i_cmd,
    input  c8core_pkg::t_item    i_item,
    output c8core_pkg::t_dp_stat o_stat,
    output c8core_pkg::t_result  o_result,
    output logic                 o_out_valid,
    input  logic                 i_out_ready
);
    import c8core_pkg::*;

    localparam logic [MEM_AW-1:0] PC_RESET = MEM_AW'(PROGRAM_START);
    localparam logic [VREG_AW-1:0] VF_INDEX = 4'hF;
    localparam logic [VREG_AW-1:0] V0_INDEX = 4'h0;

    // Major opcode nibbles.
    localparam logic [3:0] OPC_SYS  = 4'h0, OPC_JP   = 4'h1, OPC_CALL = 4'h2;
    localparam logic [3:0] OPC_SEB  = 4'h3, OPC_SNEB = 4'h4, OPC_SER  = 4'h5;
    localparam logic [3:0] OPC_LDB  = 4'h6, OPC_ADDB = 4'h7, OPC_ALU  = 4'h8;
    localparam logic [3:0] OPC_SNER = 4'h9, OPC_LDI  = 4'hA, OPC_JPV0 = 4'hB;
    localparam logic [3:0] OPC_RND  = 4'hC, OPC_DRW  = 4'hD, OPC_KEY  = 4'hE;
    localparam logic [3:0] OPC_MISC = 4'hF;
    localparam logic [15:0] WORD_CLS = 16'h00E0;
    localparam logic [15:0] WORD_RET = 16'h00EE;
    // Register-to-register operations.
    localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR  = 4'h1, ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3, ALU_ADD = 4'h4, ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6, ALU_SUBN = 4'h7, ALU_SHL = 4'hE;
    // Key-test and miscellaneous sub-codes.
    localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
    localparam logic [7:0] MS_GET_DT = 8'h07, MS_WAIT_KEY = 8'h0A, MS_SET_DT = 8'h15;
    localparam logic [7:0] MS_SET_ST = 8'h18, MS_ADD_I  = 8'h1E, MS_FONT   = 8'h29;
    localparam logic [7:0] MS_BCD    = 8'h33, MS_STORE  = 8'h55, MS_LOAD   = 8'h65;

    // Architectural state.
    logic [MEM_AW-1:0]     r_pc;
    logic [15:0]           r_index;
    logic [SP_W-1:0]       r_sp;
    logic [MEM_AW-1:0]     r_stack [STACK_DEPTH];
    logic [7:0]            r_dt, r_st;
    logic [FRAME_COLS-1:0] r_frame [FRAME_ROWS];
    logic                  r_out_valid;
    // Per-item working registers.
    t_item                 r_item;
    logic [15:0]           r_word;
    logic [7:0]            r_vx, r_vy, r_v0;
    logic                  r_flag, r_illegal, r_wait;
    logic [7:0]            r_rbyte;
    logic [FRAME_COLS-1:0] r_row;
    t_result               r_out;

    // Memory ports.
    logic                  mem_we;
    logic [MEM_AW-1:0]     mem_waddr, mem_raddr;
    logic [7:0]            mem_wdata, mem_rdata;
    logic                  v_we;
    logic [VREG_AW-1:0]    v_waddr, v_raddr;
    logic [7:0]            v_wdata, v_rdata;

    logic [3:0]            cnt_lo;
    logic [MEM_AW-1:0]     idx_addr;
    logic [3:0]            x_f;
    logic [7:0]            kk;
    logic [MEM_AW-1:0]     nnn;

    // Execute decode results.
    t_seq                  e_seq;
    logic                  e_illegal, e_wait, e_flag;
    logic                  e_vx_we, e_pc_we, e_i_we, e_call, e_ret, e_cls, e_dt_we, e_st_we;
    logic [7:0]            e_vx_val;
    logic [MEM_AW-1:0]     e_pc_val;
    logic [15:0]           e_i_val;
    logic [8:0]            alu_sum;
    logic                  key_down, key_any;
    logic [3:0]            key_idx;
    logic [SP_W-1:0]       sp_inc;

    // Sprite merge.
    logic [ROW_AW-1:0]       draw_row;
    logic [2*FRAME_COLS-1:0] draw_wide;
    logic [FRAME_COLS-1:0]   draw_mask;
    logic                    draw_hit;

    // One decimal digit of an 8-bit value: hundreds, tens or ones.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [3:0]  o;
        if (v >= 8'd200) begin
            h = 2'd2;
            r = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            h = 2'd1;
            r = 7'(v - 8'd100);
        end else begin
            h = 2'd0;
            r = v[6:0];
        end
        // Tens by reciprocal multiply; exact for values below 100.
        p = 15'({8'd0, r} * 15'd205);
        t = p[14:11];
        o = 4'(r - 7'({t, 3'b000}) - 7'({t, 1'b0}));
        case (sel)
            2'd0:    bcd_digit = {6'd0, h};
            2'd1:    bcd_digit = {4'd0, t};
            default: bcd_digit = {4'd0, o};
        endcase
    endfunction

    assign cnt_lo   = i_cmd.cnt[3:0];
    assign idx_addr = MEM_AW'(r_index[MEM_AW-1:0] + {8'd0, cnt_lo});
    assign x_f      = r_word[11:8];
    assign kk       = r_word[7:0];
    assign nnn      = r_word[11:0];
    assign sp_inc   = SP_W'(r_sp + 1'b1);

    // Main memory and register file.
    c8core_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    c8core_ram #(.WIDTH(8), .DEPTH(NUM_VREGS)) u_vregs (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    // Main memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_addr;
        mem_wdata = v_rdata;
        mem_raddr = r_pc;
        case (i_cmd.step)
            STEP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = i_cmd.cnt;
                mem_wdata = (i_cmd.cnt < MEM_AW'(FONT_BYTES)) ?
                            FONT[i_cmd.cnt[FONT_AW-1:0]] : 8'd0;
            end
            STEP_MEM_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = r_item.address;
                mem_wdata = r_item.write_data;
            end
            STEP_BCD: begin
                mem_we    = 1'b1;
                mem_wdata = bcd_digit(r_vx, cnt_lo[1:0]);
            end
            STEP_STORE_WR: mem_we = 1'b1;
            default: ;
        endcase
        case (i_cmd.step)
            STEP_FETCH_LO:                 mem_raddr = MEM_AW'(r_pc + 1'b1);
            STEP_RD_ADDR:                  mem_raddr = r_item.address;
            STEP_DRAW_RD, STEP_LOAD_RD:    mem_raddr = idx_addr;
            default:                       mem_raddr = r_pc;
        endcase
    end

    // Register file port control.
    always_comb begin
        v_we    = 1'b0;
        v_waddr = cnt_lo;
        v_wdata = 8'd0;
        case (i_cmd.step)
            STEP_CLEAR: v_we = (i_cmd.cnt[MEM_AW-1:VREG_AW] == '0);
            STEP_EXEC: begin
                v_we    = e_vx_we;
                v_waddr = x_f;
                v_wdata = e_vx_val;
            end
            STEP_FLAG: begin
                v_we    = 1'b1;
                v_waddr = VF_INDEX;
                v_wdata = {7'd0, r_flag};
            end
            STEP_LOAD_WR: begin
                v_we    = 1'b1;
                v_wdata = mem_rdata;
            end
            default: ;
        endcase
        case (i_cmd.step)
            STEP_FETCH_LO: v_raddr = mem_rdata[3:0];
            STEP_LOAD_VX:  v_raddr = mem_rdata[7:4];
            STEP_STORE_RD: v_raddr = cnt_lo;
            default:       v_raddr = V0_INDEX;
        endcase
    end

    // Key lookup for the key-test and wait-for-key instructions.
    always_comb begin
        key_down = (r_vx[7:4] == 4'd0) && r_item.key_mask[r_vx[3:0]];
        key_any  = |r_item.key_mask;
        key_idx  = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_item.key_mask[k]) begin
                key_idx = 4'(k);
            end
        end
    end

    // Instruction decode and combinational execute logic.
    always_comb begin
        e_seq     = SEQ_DONE;
        e_illegal = 1'b0;
        e_wait    = 1'b0;
        e_flag    = 1'b0;
        e_vx_we   = 1'b0;
        e_vx_val  = r_vx;
        e_pc_we   = 1'b0;
        e_pc_val  = MEM_AW'(r_pc + 12'd2);
        e_i_we    = 1'b0;
        e_i_val   = r_index;
        e_call    = 1'b0;
        e_ret     = 1'b0;
        e_cls     = 1'b0;
        e_dt_we   = 1'b0;
        e_st_we   = 1'b0;
        alu_sum   = {1'b0, r_vx} + {1'b0, r_vy};
        unique case (r_word[15:12])
            OPC_SYS: begin
                if (r_word == WORD_CLS) begin
                    e_cls = 1'b1;
                end else if (r_word == WORD_RET) begin
                    e_ret = 1'b1;
                end else begin
                    e_illegal = 1'b1;
                end
            end
            OPC_JP: begin
                e_pc_we  = 1'b1;
                e_pc_val = nnn;
            end
            OPC_CALL: e_call = 1'b1;
            OPC_SEB:  e_pc_we = (r_vx == kk);
            OPC_SNEB: e_pc_we = (r_vx != kk);
            OPC_SER:  e_pc_we = (r_vx == r_vy);
            OPC_LDB: begin
                e_vx_we  = 1'b1;
                e_vx_val = kk;
            end
            OPC_ADDB: begin
                e_vx_we  = 1'b1;
                e_vx_val = 8'(r_vx + kk);
            end
            OPC_ALU: begin
                e_vx_we = 1'b1;
                e_seq   = SEQ_FLAG;
                unique case (r_word[3:0]) inside
                    ALU_MOV: begin
                        e_vx_val = r_vy;
                        e_seq    = SEQ_DONE;
                    end
                    ALU_OR:  e_vx_val = r_vx | r_vy;
                    ALU_AND: e_vx_val = r_vx & r_vy;
                    ALU_XOR: e_vx_val = r_vx ^ r_vy;
                    ALU_ADD: begin
                        e_vx_val = alu_sum[7:0];
                        e_flag   = alu_sum[8];
                    end
                    ALU_SUB: begin
                        e_vx_val = 8'(r_vx - r_vy);
                        e_flag   = (r_vx >= r_vy);
                    end
                    ALU_SHR: begin
                        e_vx_val = {1'b0, r_vx[7:1]};
                        e_flag   = r_vx[0];
                    end
                    ALU_SUBN: begin
                        e_vx_val = 8'(r_vy - r_vx);
                        e_flag   = (r_vy >= r_vx);
                    end
                    ALU_SHL: begin
                        e_vx_val = {r_vx[6:0], 1'b0};
                        e_flag   = r_vx[7];
                    end
                    default: begin
                        e_vx_we   = 1'b0;
                        e_seq     = SEQ_DONE;
                        e_illegal = 1'b1;
                    end
                endcase
            end
            OPC_SNER: e_pc_we = (r_vx != r_vy);
            OPC_LDI: begin
                e_i_we  = 1'b1;
                e_i_val = {4'd0, nnn};
            end
            OPC_JPV0: begin
                e_pc_we  = 1'b1;
                e_pc_val = MEM_AW'(nnn + {4'd0, r_v0});
            end
            OPC_RND: begin
                e_vx_we  = 1'b1;
                e_vx_val = r_item.random_byte & kk;
            end
            OPC_DRW: e_seq = (r_word[3:0] == 4'd0) ? SEQ_FLAG : SEQ_DRAW;
            OPC_KEY: begin
                unique case (kk) inside
                    KEY_DOWN: e_pc_we = key_down;
                    KEY_UP:   e_pc_we = !key_down;
                    default:  e_illegal = 1'b1;
                endcase
            end
            OPC_MISC: begin
                unique case (kk) inside
                    MS_GET_DT: begin
                        e_vx_we  = 1'b1;
                        e_vx_val = r_dt;
                    end
                    MS_WAIT_KEY: begin
                        if (key_any) begin
                            e_vx_we  = 1'b1;
                            e_vx_val = {4'd0, key_idx};
                        end else begin
                            e_pc_we  = 1'b1;
                            e_pc_val = MEM_AW'(r_pc - 12'd2);
                            e_wait   = 1'b1;
                        end
                    end
                    MS_SET_DT: e_dt_we = 1'b1;
                    MS_SET_ST: e_st_we = 1'b1;
                    MS_ADD_I: begin
                        e_i_we  = 1'b1;
                        e_i_val = 16'(r_index + {8'd0, r_vx});
                    end
                    MS_FONT: begin
                        e_i_we  = 1'b1;
                        e_i_val = 16'({6'd0, r_vx, 2'b00} + {8'd0, r_vx});
                    end
                    MS_BCD:   e_seq = SEQ_BCD;
                    MS_STORE: e_seq = SEQ_STORE;
                    MS_LOAD:  e_seq = SEQ_LOAD;
                    default:  e_illegal = 1'b1;
                endcase
            end
            default: e_illegal = 1'b1;
        endcase
    end

    // Sprite byte placed at the start column, wrapping around the row.
    always_comb begin
        draw_row  = ROW_AW'(r_vy[ROW_AW-1:0] + {1'b0, cnt_lo});
        draw_wide = {mem_rdata, 56'd0, mem_rdata, 56'd0} >> r_vx[COL_AW-1:0];
        draw_mask = draw_wide[FRAME_COLS-1:0];
        draw_hit  = |(r_frame[draw_row] & draw_mask);
    end

    // Architectural state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_RESET;
            r_index     <= '0;
            r_sp        <= '0;
            r_stack     <= '{default: '0};
            r_dt        <= '0;
            r_st        <= '0;
            r_frame     <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            // A freshly loaded result takes precedence over the leaving beat.
            if (i_cmd.step == STEP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.step)
                STEP_TICK: begin
                    if (r_dt != 8'd0) r_dt <= 8'(r_dt - 1'b1);
                    if (r_st != 8'd0) r_st <= 8'(r_st - 1'b1);
                end
                STEP_LOAD_VX: r_pc <= MEM_AW'(r_pc + 12'd2);
                STEP_EXEC: begin
                    if (e_pc_we) r_pc <= e_pc_val;
                    if (e_i_we)  r_index <= e_i_val;
                    if (e_dt_we) r_dt <= r_vx;
                    if (e_st_we) r_st <= r_vx;
                    if (e_cls)   r_frame <= '{default: '0};
                    if (e_call) begin
                        r_sp            <= sp_inc;
                        r_stack[sp_inc] <= r_pc;
                        r_pc            <= nnn;
                    end
                    if (e_ret) begin
                        r_pc <= r_stack[r_sp];
                        r_sp <= SP_W'(r_sp - 1'b1);
                    end
                end
                STEP_DRAW_WR: r_frame[draw_row] <= r_frame[draw_row] ^ draw_mask;
                STEP_STORE_WR, STEP_LOAD_WR: begin
                    if (cnt_lo == x_f) begin
                        r_index <= 16'(r_index + {12'd0, x_f} + 16'd1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-item working registers and the result register.
    always_ff @(posedge i_clk) begin
        case (i_cmd.step)
            STEP_LATCH: begin
                r_item    <= i_item;
                r_word    <= '0;
                r_illegal <= 1'b0;
                r_wait    <= 1'b0;
                r_rbyte   <= '0;
                r_row     <= '0;
            end
            STEP_ROW:      r_row <= r_frame[r_item.address[ROW_AW-1:0]];
            STEP_RD_DATA:  r_rbyte <= mem_rdata;
            STEP_FETCH_LO: r_word[15:8] <= mem_rdata;
            STEP_LOAD_VX: begin
                r_word[7:0] <= mem_rdata;
                r_vx        <= v_rdata;
            end
            STEP_LOAD_VY: r_vy <= v_rdata;
            STEP_LOAD_V0: r_v0 <= v_rdata;
            STEP_EXEC: begin
                r_illegal <= e_illegal;
                r_wait    <= e_wait;
                r_flag    <= e_flag;
            end
            STEP_DRAW_WR: begin
                if (draw_hit) r_flag <= 1'b1;
            end
            STEP_RESULT: begin
                r_out.program_counter     <= r_pc;
                r_out.instruction_word    <= r_word;
                r_out.illegal_instruction <= r_illegal;
                r_out.waiting_key         <= r_wait;
                r_out.sound_on            <= (r_st != 8'd0);
                r_out.read_byte           <= r_rbyte;
                r_out.pixel_row           <= r_row;
            end
            default: ;
        endcase
    end

    assign o_result    = r_out;
    assign o_out_valid = r_out_valid;

    assign o_stat.seq      = e_seq;
    assign o_stat.n        = r_word[3:0];
    assign o_stat.x        = x_f;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // A new result only replaces a beat that is gone or leaving.
    `C8_ASSERT_IMPL(a_result_slot_free, i_clk, i_rst_n, i_cmd.step == STEP_RESULT, !r_out_valid || i_out_ready, "result loaded over a pending beat")
    // A loaded result is offered in the next cycle.
    `C8_ASSERT_NEXT(a_result_offered, i_clk, i_rst_n, i_cmd.step == STEP_RESULT, r_out_valid, "result not offered after load")
    // A subroutine call pushes exactly one stack entry.
    `C8_ASSERT_NEXT(a_call_push, i_clk, i_rst_n, i_cmd.step == STEP_EXEC && e_call, r_sp == SP_W'($past(r_sp) + 1'b1), "call did not advance stack pointer")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 instruction core testbench
// Drives memory writes, instruction execution, timer ticks, row reads and
// memory reads through the item channel and compares every result beat with
// a behavioral model of the interpreter kept inside this module.
// ----------------------------------------------------------------------------
module tb;
    import c8core_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    logic i_clk;
    logic i_rst_n;

    c8core_item_if   item_ch ();
    c8core_result_if result_ch ();

    chip8_instruction_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .o_result (result_ch.source)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Interpreter state mirrored by the predictor.
    logic [7:0]  mem_img [MEM_BYTES];
    logic [7:0]  vreg [NUM_VREGS];
    logic [11:0] call_stack [STACK_DEPTH];
    logic [3:0]  sp;
    logic [11:0] pc;
    logic [15:0] index_r;
    logic [7:0]  delay_t;
    logic [7:0]  sound_t;
    logic [63:0] screen [FRAME_ROWS];

    t_result pending_q[$];
    int      fail_count;
    int      beats_checked;
    int      exec_count;
    int      cycle_count;
    bit      hold_off;
    bit      stall_enable;

    // Bring the model to its post-reset contents.
    task automatic model_reset();
        for (int i = 0; i < MEM_BYTES; i++) mem_img[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
        for (int i = 0; i < NUM_VREGS; i++) vreg[i] = 8'h00;
        for (int i = 0; i < STACK_DEPTH; i++) call_stack[i] = 12'h000;
        for (int i = 0; i < FRAME_ROWS; i++) screen[i] = 64'h0;
        sp = 4'd0;
        pc = 12'd512;
        index_r = 16'h0;
        delay_t = 8'h00;
        sound_t = 8'h00;
    endtask

    function automatic void cond_skip(bit c);
        if (c) pc = pc + 12'd2;
    endfunction

    // Execute one instruction word; returns the illegal flag.
    function automatic bit run_instr(logic [15:0] w, logic [15:0] keys, logic [7:0] rnd,
                                     ref bit stalled);
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  kk;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [7:0]  flag;
        logic [7:0]  bits;
        logic [5:0]  x0;
        logic [4:0]  y0;
        logic [4:0]  row;
        logic [5:0]  col;
        logic [8:0]  sum;
        bit          hit;
        bit          down;
        x = w[11:8];
        y = w[7:4];
        n = w[3:0];
        kk = w[7:0];
        vx = vreg[x];
        vy = vreg[y];
        case (w[15:12])
            4'h0: begin
                if (w == 16'h00E0) begin
                    for (int i = 0; i < FRAME_ROWS; i++) screen[i] = 64'h0;
                    return 1'b0;
                end
                if (w == 16'h00EE) begin
                    pc = call_stack[sp];
                    sp = sp - 4'd1;
                    return 1'b0;
                end
                return 1'b1;
            end
            4'h1: pc = w[11:0];
            4'h2: begin
                sp = sp + 4'd1;
                call_stack[sp] = pc;
                pc = w[11:0];
            end
            4'h3: cond_skip(vx == kk);
            4'h4: cond_skip(vx != kk);
            4'h5: cond_skip(vx == vy);
            4'h6: vreg[x] = kk;
            4'h7: vreg[x] = vx + kk;
            4'h8: begin
                case (n)
                    4'h0: vreg[x] = vy;
                    4'h1: begin vreg[x] = vx | vy; vreg[15] = 8'h00; end
                    4'h2: begin vreg[x] = vx & vy; vreg[15] = 8'h00; end
                    4'h3: begin vreg[x] = vx ^ vy; vreg[15] = 8'h00; end
                    4'h4: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = sum[7:0];
                        vreg[15] = {7'd0, sum[8]};
                    end
                    4'h5: begin
                        flag = {7'd0, vx >= vy};
                        vreg[x] = vx - vy;
                        vreg[15] = flag;
                    end
                    4'h6: begin vreg[x] = vx >> 1; vreg[15] = {7'd0, vx[0]}; end
                    4'h7: begin
                        flag = {7'd0, vy >= vx};
                        vreg[x] = vy - vx;
                        vreg[15] = flag;
                    end
                    4'hE: begin vreg[x] = vx << 1; vreg[15] = {7'd0, vx[7]}; end
                    default: return 1'b1;
                endcase
            end
            4'h9: cond_skip(vx != vy);
            4'hA: index_r = {4'h0, w[11:0]};
            4'hB: pc = w[11:0] + {4'h0, vreg[0]};
            4'hC: vreg[x] = rnd & kk;
            4'hD: begin
                // Sprite rows are XORed in with wraparound on both axes.
                x0 = vx[5:0];
                y0 = vy[4:0];
                hit = 1'b0;
                for (int i = 0; i < n; i++) begin
                    bits = mem_img[12'(index_r + 16'(i))];
                    row = y0 + 5'(i);
                    for (int j = 0; j < 8; j++) begin
                        if (bits[7-j]) begin
                            col = x0 + 6'(j);
                            if (screen[row][63-col]) hit = 1'b1;
                            screen[row][63-col] = ~screen[row][63-col];
                        end
                    end
                end
                vreg[15] = {7'd0, hit};
            end
            4'hE: begin
                down = (vx < 16) && keys[vx[3:0]];
                if (kk == 8'h9E) cond_skip(down);
                else if (kk == 8'hA1) cond_skip(!down);
                else return 1'b1;
            end
            default: begin
                case (kk)
                    8'h07: vreg[x] = delay_t;
                    8'h0A: begin
                        // The lowest pressed key wins; no key rewinds the counter.
                        for (int i = 0; i < 16; i++) begin
                            if (keys[i]) begin
                                vreg[x] = 8'(i);
                                return 1'b0;
                            end
                        end
                        pc = pc - 12'd2;
                        stalled = 1'b1;
                    end
                    8'h15: delay_t = vx;
                    8'h18: sound_t = vx;
                    8'h1E: index_r = index_r + {8'h0, vx};
                    8'h29: index_r = 16'(5 * vx);
                    8'h33: begin
                        mem_img[12'(index_r)] = 8'(vx / 100);
                        mem_img[12'(index_r + 16'd1)] = 8'((vx / 10) % 10);
                        mem_img[12'(index_r + 16'd2)] = 8'(vx % 10);
                    end
                    8'h55: begin
                        for (int i = 0; i <= x; i++) mem_img[12'(index_r + 16'(i))] = vreg[i];
                        index_r = index_r + 16'(x) + 16'd1;
                    end
                    8'h65: begin
                        for (int i = 0; i <= x; i++) vreg[i] = mem_img[12'(index_r + 16'(i))];
                        index_r = index_r + 16'(x) + 16'd1;
                    end
                    default: return 1'b1;
                endcase
            end
        endcase
        return 1'b0;
    endfunction

    // Compute the result beat for one item and update the model.
    function automatic t_result predict_beat(t_item it);
        t_result r;
        bit      stalled;
        r = '0;
        stalled = 1'b0;
        case (it.opcode)
            KIND_WRITE: mem_img[it.address] = it.write_data;
            KIND_EXEC: begin
                r.instruction_word = {mem_img[pc], mem_img[12'(pc + 12'd1)]};
                pc = pc + 12'd2;
                r.illegal_instruction = run_instr(r.instruction_word, it.key_mask,
                                                  it.random_byte, stalled);
            end
            KIND_TICK: begin
                if (delay_t != 0) delay_t--;
                if (sound_t != 0) sound_t--;
            end
            KIND_ROW: r.pixel_row = screen[it.address[4:0]];
            KIND_READ: r.read_byte = mem_img[it.address];
            default: ;
        endcase
        r.program_counter = pc;
        r.waiting_key = stalled;
        r.sound_on = (sound_t != 0);
        return r;
    endfunction

    // Random gap: mostly none or short, now and then long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one item beat and record its expected result at acceptance.
    task automatic send_item(t_item it, bit idle_gaps = 1'b1);
        int g;
        g = idle_gaps ? gap_len() : 0;
        repeat (g) @(posedge i_clk);
        item_ch.valid <= 1'b1;
        item_ch.payload <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        pending_q.push_back(predict_beat(it));
        if (it.opcode == KIND_EXEC) exec_count++;
        // Valid drops for one cycle; the core is busy right after a beat anyway.
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_item make_item(logic [2:0] op, logic [11:0] a = '0,
                                        logic [7:0] d = '0, logic [15:0] k = '0,
                                        logic [7:0] rnd = '0);
        t_item it;
        it.opcode = op;
        it.address = a;
        it.write_data = d;
        it.key_mask = k;
        it.random_byte = rnd;
        return it;
    endfunction

    // Place an instruction word at the current counter, then run it.
    task automatic run_word(logic [15:0] w, logic [15:0] k = '0, logic [7:0] rnd = '0);
        send_item(make_item(KIND_WRITE, pc, w[15:8]));
        send_item(make_item(KIND_WRITE, 12'(pc + 12'd1), w[7:0]));
        send_item(make_item(KIND_EXEC, 12'($urandom), 8'($urandom), k, rnd));
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Result checker; the receiver stalls at random or during a hold-off.
    always @(posedge i_clk) begin
        t_result e;
        t_result a;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                a = result_ch.payload;
                if (pending_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    e = pending_q.pop_front();
                    beats_checked++;
                    if (a.program_counter !== e.program_counter) begin
                        $error("program_counter exp %h got %h", e.program_counter,
                               a.program_counter);
                        fail_count++;
                    end
                    if (a.instruction_word !== e.instruction_word) begin
                        $error("instruction_word exp %h got %h", e.instruction_word,
                               a.instruction_word);
                        fail_count++;
                    end
                    if (a.illegal_instruction !== e.illegal_instruction) begin
                        $error("illegal_instruction exp %b got %b",
                               e.illegal_instruction, a.illegal_instruction);
                        fail_count++;
                    end
                    if (a.waiting_key !== e.waiting_key) begin
                        $error("waiting_key exp %b got %b", e.waiting_key, a.waiting_key);
                        fail_count++;
                    end
                    if (a.sound_on !== e.sound_on) begin
                        $error("sound_on exp %b got %b", e.sound_on, a.sound_on);
                        fail_count++;
                    end
                    if (a.read_byte !== e.read_byte) begin
                        $error("read_byte exp %h got %h", e.read_byte, a.read_byte);
                        fail_count++;
                    end
                    if (a.pixel_row !== e.pixel_row) begin
                        $error("pixel_row exp %h got %h", e.pixel_row, a.pixel_row);
                        fail_count++;
                    end
                end
            end
            if (hold_off) result_ch.ready <= 1'b0;
            else if (stall_enable) result_ch.ready <= ($urandom_range(0, 99) < 70);
            else result_ch.ready <= 1'b1;
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Directed: memory write/read extremes and font rows.
    task automatic test_memory_access();
        send_item(make_item(KIND_READ, 12'd0));
        send_item(make_item(KIND_READ, 12'd79));
        send_item(make_item(KIND_WRITE, 12'hFFF, 8'hFF));
        send_item(make_item(KIND_READ, 12'hFFF));
        send_item(make_item(KIND_WRITE, 12'h800, 8'hA5));
        send_item(make_item(KIND_READ, 12'h800));
        send_item(make_item(KIND_ROW, 12'hFFF));
        send_item(make_item(3'd7, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF));
    endtask

    // Directed: timers, draw with wraparound, BCD, store/load, key wait.
    task automatic test_instructions();
        run_word(16'h6005);                // V0 = 5
        run_word(16'hF018);                // sound = 5
        run_word(16'hF015);                // delay = 5
        send_item(make_item(KIND_TICK));
        run_word(16'hF107);
        run_word(16'h623F);                // V2 = 63
        run_word(16'h631F);                // V3 = 31
        run_word(16'hF029);                // font glyph 5
        run_word(16'hD235);                // draw at the corner, wraps
        run_word(16'hD235);                // second draw collides
        send_item(make_item(KIND_ROW, 12'd31));
        run_word(16'h64FF);
        run_word(16'hAFFE);
        run_word(16'hF433);                // BCD across the top of memory
        run_word(16'hFF55);
        run_word(16'hFF65);
        run_word(16'hF50A, 16'h0000);      // no key: rewinds
        send_item(make_item(KIND_EXEC, 12'd0, 8'd0, 16'h8010));
        run_word(16'h0123);                // undefined
        run_word(16'h2FFE);                // call near the top
        run_word(16'h00EE);
        run_word(16'h00EE);                // underflow
        run_word(16'h00E0);
    endtask

    function automatic logic [15:0] random_word();
        logic [15:0] w;
        int p;
        w = 16'($urandom);
        p = $urandom_range(0, 99);
        // Bias toward defined sub-codes of the 0, E and F groups.
        if (p < 10) w = (p < 5) ? 16'h00E0 : 16'h00EE;
        else if (p < 15) w[7:0] = (p < 13) ? 8'h9E : 8'hA1;
        else if (p < 40 && w[15:12] == 4'hF) begin
            case ($urandom_range(0, 8))
                0: w[7:0] = 8'h07; 1: w[7:0] = 8'h0A; 2: w[7:0] = 8'h15;
                3: w[7:0] = 8'h18; 4: w[7:0] = 8'h1E; 5: w[7:0] = 8'h29;
                6: w[7:0] = 8'h33; 7: w[7:0] = 8'h55; default: w[7:0] = 8'h65;
            endcase
        end
        // Keep sprites mostly short.
        if (w[15:12] == 4'hD && $urandom_range(0, 3) != 0) w[3:0] = 4'($urandom_range(0, 5));
        return w;
    endfunction

    function automatic logic [15:0] random_keys();
        case ($urandom_range(0, 3))
            0: return 16'h0;
            1: return 16'h1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // Random: mostly written-then-executed words, plus raw items of every kind.
    task automatic test_random_mix(int count);
        int p;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(0, 99);
            if (p < 55) run_word(random_word(), random_keys(), 8'($urandom));
            else if (p < 65) send_item(make_item(KIND_EXEC, 12'($urandom), 8'($urandom),
                                                 random_keys(), 8'($urandom)));
            else if (p < 75) send_item(make_item(KIND_TICK));
            else if (p < 85) send_item(make_item(KIND_ROW, 12'($urandom)));
            else if (p < 95) send_item(make_item(KIND_READ, 12'($urandom)));
            else send_item(make_item(3'($urandom), 12'($urandom), 8'($urandom),
                                     16'($urandom), 8'($urandom)));
        end
    endtask

    // Receiver holds off while the sender keeps offering; then drain fully.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++) begin
                send_item(make_item(KIND_READ, 12'($urandom)), 1'b0);
            end
        join
        wait_drained();
        stall_enable = 1'b0;
        test_random_mix(40);
        stall_enable = 1'b1;
    endtask

    initial begin
        fail_count = 0;
        beats_checked = 0;
        exec_count = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        stall_enable = 1'b1;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        model_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_memory_access();
        test_instructions();
        test_backpressure();
        test_random_mix(340);

        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("Checked %0d result beats, %0d of them from executed instructions.",
                 beats_checked, exec_count);
        if (fail_count == 0 && pending_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
